// File: hdl/assert_macros.svh
// Assertion macros used by the sequencer RTL file (rbna_ctrl.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/rbna_pkg.sv
// Shared types and constants of the range block number allocator.
package rbna_pkg;

  localparam int MaxBlocks  = 16;
  localparam int NumWidth   = 32;
  localparam int FieldWidth = 32;
  localparam int ExtWidth   = 64;

  typedef enum logic [2:0] {
    REQ_ADD   = 3'd0,
    REQ_GET   = 3'd1,
    REQ_USE   = 3'd2,
    REQ_DEL   = 3'd3,
    REQ_QUERY = 3'd4
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ADD,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic untouched;
    logic get_hit;
    logic use_hit;
    logic key_eq;
    logic start_gt;
  } match_flags_t;

endpackage

// File: hdl/range_block_number_allocator.sv
// Range block number allocator: keeps a sorted table of reserved number blocks.
//
// Input channel s_axis: one word per request. tuser carries the request kind
// (add, get free, use, delete, reserve query); tdata carries block_start,
// block_end and number. The block takes one request at a time: tready is high
// only while the sequencer is idle.
// Output channel m_axis: one word per request. tuser carries ok, tdata the
// free number (zero unless a get request found one).
// Each request goes through setup, a walk over the table rows one at a time
// through the single read port of the table memory, and hand-over of the
// result. Get, use and reserve query stop at the first row that answers or
// at the end of the table; add moves rows up one place until the new row's
// place is reached; delete walks to the match and then moves every later
// row down.
// Reset empties the table at once (row count to zero); no clearing pass.
// The result sits in an output register; a new request is taken while it
// waits, and the sequencer holds its next result until m_axis takes the old.
module range_block_number_allocator #(
  parameter int MAX_BLOCKS = rbna_pkg::MaxBlocks,
  parameter int NUM_WIDTH  = rbna_pkg::NumWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // block_start[31:0], block_end[63:32], number[95:64]
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // free_number[31:0]
  output logic [0:0]  m_axis_tuser    // ok[0]
);

  import rbna_pkg::*;

  localparam int AddrWidth = MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1;
  localparam int RowWidth  = 3 * NUM_WIDTH + 1;

  logic [ExtWidth-1:0]  start_ext;
  logic [ExtWidth-1:0]  end_ext;
  logic [ExtWidth-1:0]  number_ext;
  logic [ExtWidth-1:0]  res_num_ext;

  logic [RowWidth-1:0]  rdata;
  logic [RowWidth-1:0]  wdata;
  logic [AddrWidth-1:0] raddr;
  logic [AddrWidth-1:0] waddr;
  logic                 we;
  match_flags_t         flags;
  logic [NUM_WIDTH-1:0] match_num;
  logic [NUM_WIDTH-1:0] key;
  logic                 res_valid;
  logic                 res_ready;
  logic                 res_ok;
  logic [NUM_WIDTH-1:0] res_num;

  logic                 m_valid_q, m_valid_d;
  logic                 m_ok_q;
  logic [FieldWidth-1:0] m_num_q;

  // keep numbers to NUM_WIDTH bits
  assign start_ext  = ExtWidth'(s_axis_tdata[FieldWidth-1:0]);
  assign end_ext    = ExtWidth'(s_axis_tdata[2*FieldWidth-1:FieldWidth]);
  assign number_ext = ExtWidth'(s_axis_tdata[3*FieldWidth-1:2*FieldWidth]);

  rbna_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .NUM_WIDTH  (NUM_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (req_type_e'(s_axis_tuser)),
    .in_start_i  (start_ext[NUM_WIDTH-1:0]),
    .in_end_i    (end_ext[NUM_WIDTH-1:0]),
    .in_number_i (number_ext[NUM_WIDTH-1:0]),
    .rdata_i     (rdata),
    .flags_i     (flags),
    .num_i       (match_num),
    .key_o       (key),
    .raddr_o     (raddr),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_ok_o    (res_ok),
    .res_num_o   (res_num)
  );

  rbna_table #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .NUM_WIDTH  (NUM_WIDTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rbna_match #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_match (
    .row_i   (rdata),
    .key_i   (key),
    .flags_o (flags),
    .num_o   (match_num)
  );

  // output register: load when empty or being drained
  assign res_ready   = !m_valid_q || m_axis_tready;
  assign res_num_ext = ExtWidth'(res_num);

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_ok_q  <= res_ok;
      m_num_q <= res_num_ext[FieldWidth-1:0];
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_num_q;
  assign m_axis_tuser[0] = m_ok_q;

endmodule

// File: hdl/rbna_table.sv
// Block table memory: one write port, one registered read port.
module rbna_table #(
  parameter int MAX_BLOCKS = 16,
  parameter int NUM_WIDTH  = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [(MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1)-1:0] waddr_i,
  input  logic [3*NUM_WIDTH:0]                         wdata_i,
  input  logic [(MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1)-1:0] raddr_i,
  output logic [3*NUM_WIDTH:0]                         rdata_o
);

  localparam int RowWidth = 3 * NUM_WIDTH + 1;

  logic [RowWidth-1:0] mem [MAX_BLOCKS];
  logic [RowWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rbna_match.sv
// Shared compare unit: checks one table row against the request key.
module rbna_match #(
  parameter int NUM_WIDTH = 32
) (
  input  logic [3*NUM_WIDTH:0]        row_i,
  input  logic [NUM_WIDTH-1:0]        key_i,
  output rbna_pkg::match_flags_t      flags_o,
  output logic [NUM_WIDTH-1:0]        num_o
);

  import rbna_pkg::*;

  logic [NUM_WIDTH-1:0] row_start;
  logic [NUM_WIDTH-1:0] row_end;
  logic [NUM_WIDTH-1:0] row_last;
  logic                 row_touched;

  assign row_start   = row_i[NUM_WIDTH-1:0];
  assign row_end     = row_i[2*NUM_WIDTH-1:NUM_WIDTH];
  assign row_last    = row_i[3*NUM_WIDTH-1:2*NUM_WIDTH];
  assign row_touched = row_i[3*NUM_WIDTH];

  always_comb begin
    flags_o.untouched = !row_touched;
    flags_o.get_hit   = !row_touched || (row_last < row_end);
    flags_o.use_hit   = (row_start <= key_i) && (row_end >= key_i);
    flags_o.key_eq    = (row_start == key_i);
    flags_o.start_gt  = (row_start > key_i);
  end

  // untouched rows hand out their start, touched rows the number after last
  assign num_o = row_touched ? (row_last + NUM_WIDTH'(1)) : row_start;

endmodule

// File: hdl/rbna_ctrl.sv
// Request sequencer: walks the table, shifts rows and keeps the row count.
`include "assert_macros.svh"

module rbna_ctrl #(
  parameter int MAX_BLOCKS = 16,
  parameter int NUM_WIDTH  = 32
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  rbna_pkg::req_type_e                          in_req_i,
  input  logic [NUM_WIDTH-1:0]                         in_start_i,
  input  logic [NUM_WIDTH-1:0]                         in_end_i,
  input  logic [NUM_WIDTH-1:0]                         in_number_i,
  input  logic [3*NUM_WIDTH:0]                         rdata_i,
  input  rbna_pkg::match_flags_t                       flags_i,
  input  logic [NUM_WIDTH-1:0]                         num_i,
  output logic [NUM_WIDTH-1:0]                         key_o,
  output logic [(MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1)-1:0] raddr_o,
  output logic                                         we_o,
  output logic [(MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1)-1:0] waddr_o,
  output logic [3*NUM_WIDTH:0]                         wdata_o,
  output logic                                         res_valid_o,
  input  logic                                         res_ready_i,
  output logic                                         res_ok_o,
  output logic [NUM_WIDTH-1:0]                         res_num_o
);

  import rbna_pkg::*;

  localparam int AddrWidth = MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1;
  localparam int CntWidth  = $clog2(MAX_BLOCKS + 1);

  state_e               state_q, state_d;
  req_type_e            req_q;
  logic [NUM_WIDTH-1:0] key_q;
  logic [NUM_WIDTH-1:0] end_q;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [CntWidth-1:0]  ptr_q, ptr_d;
  logic                 ok_q, ok_d;
  logic [NUM_WIDTH-1:0] num_q, num_d;

  logic                 in_fire;
  logic                 full;
  logic                 at_end;
  logic                 hole_zero;
  logic                 scan_hit;
  logic [CntWidth-1:0]  ptr_inc;
  logic [CntWidth-1:0]  ptr_dec;
  logic [CntWidth-1:0]  ptr_dec2;
  logic [CntWidth-1:0]  cnt_dec;
  logic [3*NUM_WIDTH:0] new_row;
  logic [3*NUM_WIDTH:0] use_row;
  logic                 wr_state;
  logic                 cnt_state;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (cnt_q == CntWidth'(MAX_BLOCKS));
  assign at_end     = (ptr_q == cnt_q);
  assign hole_zero  = (ptr_q == '0);
  assign ptr_inc    = ptr_q + CntWidth'(1);
  assign ptr_dec    = ptr_q - CntWidth'(1);
  assign ptr_dec2   = ptr_q - CntWidth'(2);
  assign cnt_dec    = cnt_q - CntWidth'(1);
  assign key_o      = key_q;
  assign new_row    = {1'b0, {NUM_WIDTH{1'b0}}, end_q, key_q};
  assign use_row    = {1'b1, key_q, rdata_i[2*NUM_WIDTH-1:0]};
  assign wr_state   = (state_q == ST_ADD) || (state_q == ST_SCAN) || (state_q == ST_SHIFT);
  assign cnt_state  = (state_q == ST_ADD) || (state_q == ST_SHIFT);

  always_comb begin
    unique case (req_q)
      REQ_GET:   scan_hit = flags_i.get_hit;
      REQ_USE:   scan_hit = flags_i.use_hit;
      REQ_DEL:   scan_hit = flags_i.key_eq;
      REQ_QUERY: scan_hit = flags_i.untouched;
      default:   scan_hit = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_START;
      end
      ST_START: begin
        unique case (req_q)
          REQ_ADD:                               state_d = full ? ST_DONE : ST_ADD;
          REQ_GET, REQ_USE, REQ_DEL, REQ_QUERY:  state_d = ST_SCAN;
          default:                               state_d = ST_DONE;
        endcase
      end
      ST_ADD: begin
        if (hole_zero || !flags_i.start_gt) state_d = ST_DONE;
      end
      ST_SCAN: begin
        priority if (at_end) state_d = ST_DONE;
        else if (scan_hit) state_d = (req_q == REQ_DEL) ? ST_SHIFT : ST_DONE;
        else state_d = ST_SCAN;
      end
      ST_SHIFT: begin
        if (at_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    ok_d        = ok_q;
    num_d       = num_q;
    raddr_o     = ptr_q[AddrWidth-1:0];
    we_o        = 1'b0;
    waddr_o     = ptr_q[AddrWidth-1:0];
    wdata_o     = rdata_i;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: ;
      ST_START: begin
        ok_d  = 1'b0;
        num_d = '0;
        if (req_q == REQ_ADD) begin
          // hole starts past the last row and moves down
          ptr_d   = cnt_q;
          raddr_o = cnt_dec[AddrWidth-1:0];
        end else begin
          ptr_d   = '0;
          raddr_o = '0;
        end
      end
      ST_ADD: begin
        we_o = 1'b1;
        priority if (hole_zero || !flags_i.start_gt) begin
          wdata_o = new_row;
          cnt_d   = cnt_q + CntWidth'(1);
          ok_d    = 1'b1;
        end else begin
          // move the row below the hole up one place
          ptr_d   = ptr_dec;
          raddr_o = ptr_dec2[AddrWidth-1:0];
        end
      end
      ST_SCAN: begin
        priority if (at_end) begin
          ok_d = 1'b0;
        end else if (scan_hit) begin
          ok_d = 1'b1;
          if (req_q == REQ_GET) num_d = num_i;
          if (req_q == REQ_USE) begin
            we_o    = 1'b1;
            wdata_o = use_row;
          end
          if (req_q == REQ_DEL) begin
            ptr_d   = ptr_inc;
            raddr_o = ptr_inc[AddrWidth-1:0];
          end
        end else begin
          ptr_d   = ptr_inc;
          raddr_o = ptr_inc[AddrWidth-1:0];
        end
      end
      ST_SHIFT: begin
        if (at_end) begin
          cnt_d = cnt_dec;
        end else begin
          // pull the row down over the deleted one
          we_o    = 1'b1;
          waddr_o = ptr_dec[AddrWidth-1:0];
          ptr_d   = ptr_inc;
          raddr_o = ptr_inc[AddrWidth-1:0];
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_ok_o  = ok_q;
  assign res_num_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q  <= ok_d;
    num_q <= num_d;
    if (in_fire) begin
      req_q <= in_req_i;
      key_q <= (in_req_i == REQ_USE) ? in_number_i : in_start_i;
      end_q <= in_end_i;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntWidth'(MAX_BLOCKS), "row count above table size")
  `ASSERT_IMPL(a_we_state, we_o, wr_state, "table write outside a working state")
  `ASSERT_IMPL(a_cnt_step, cnt_q != $past(cnt_q), $past(cnt_state), "row count step outside add/delete")

endmodule

// File: verif/tb_top.sv
// Testbench for the range block number allocator: directed table, random requests.
module tb_top;
  import rbna_pkg::*;

  localparam logic [2:0] REQ_RSV5 = 3'd5;
  localparam logic [2:0] REQ_RSV6 = 3'd6;
  localparam logic [2:0] REQ_RSV7 = 3'd7;
  localparam int RandItems  = 1525;
  localparam int QuietItems = 120;
  localparam int HoldCycles = 250;
  localparam int HoldAfter  = 400;
  localparam int DrainWait  = 40;
  localparam int StuckLimit = 2000;

  typedef struct packed {
    logic        ok;
    logic [31:0] free_num;
  } grant_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] num;
    logic        typed;
    logic        ok;
    logic [31:0] free_num;
  } dir_row_t;

  localparam int DirRows = 25;
  localparam dir_row_t DIRECTED [DirRows] = '{
    '{REQ_QUERY, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0},
    '{REQ_GET, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0},
    '{REQ_USE, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0},
    '{REQ_DEL, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0},
    '{REQ_RSV5, '1, '1, '1, 1'b1, 1'b0, 32'd0},
    '{REQ_RSV6, 32'd0, '1, 32'd7, 1'b1, 1'b0, 32'd0},
    '{REQ_RSV7, 32'd9, 32'd0, '1, 1'b1, 1'b0, 32'd0},
    '{REQ_ADD, 32'd0, '1, 32'd0, 1'b1, 1'b1, 32'd0},
    '{REQ_GET, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 32'd0},
    '{REQ_QUERY, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 32'd0},
    '{REQ_USE, 32'd0, 32'd0, '1, 1'b1, 1'b1, 32'd0},
    '{REQ_GET, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0},
    '{REQ_QUERY, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0},
    '{REQ_ADD, 32'd100, 32'd50, 32'd0, 1'b1, 1'b1, 32'd0},
    '{REQ_USE, 32'd0, 32'd0, 32'd75, 1'b0, 1'b0, 32'd0},
    '{REQ_GET, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{REQ_ADD, 32'd100, 32'd200, 32'd0, 1'b1, 1'b1, 32'd0},
    '{REQ_DEL, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 32'd0},
    '{REQ_USE, 32'd0, 32'd0, 32'd150, 1'b0, 1'b0, 32'd0},
    '{REQ_GET, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{REQ_DEL, 32'd100, 32'd0, 32'd0, 1'b1, 1'b1, 32'd0},
    '{REQ_GET, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{REQ_ADD, '1, '1, 32'd0, 1'b1, 1'b1, 32'd0},
    '{REQ_USE, 32'd0, 32'd0, '1, 1'b0, 1'b0, 32'd0},
    '{REQ_GET, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // block_start[31:0], block_end[63:32], number[95:64]
  logic [2:0]  s_axis_tuser = '0;   // req_type[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // free_number[31:0]
  logic [0:0]  m_axis_tuser;        // ok[0]

  // side band that travels with the word: a hand-typed grant, if any
  logic        word_typed = 1'b0;
  grant_t      word_grant = '0;

  // predictor copy of the block table
  logic [31:0] blk_start [MaxBlocks];
  logic [31:0] blk_end [MaxBlocks];
  logic [31:0] blk_last [MaxBlocks];
  logic        blk_used [MaxBlocks];
  int          blk_cnt = 0;

  grant_t      grant_q [$];
  int          mismatches = 0;
  int          stuck = 0;
  int          idle_pct = 0;
  int          words_sent = 0;
  bit          hold_done = 1'b0;

  // stimulus shaping
  logic [31:0] pool_start [$];
  logic [31:0] pool_end [$];
  logic [31:0] region_base = '0;
  int          span_max = 3;
  bit          grow = 1'b1;

  range_block_number_allocator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void copy_blk(int dst, int src);
    blk_start[dst] = blk_start[src];
    blk_end[dst]   = blk_end[src];
    blk_last[dst]  = blk_last[src];
    blk_used[dst]  = blk_used[src];
  endfunction

  // Apply one request to the table copy and return the grant it yields.
  function automatic grant_t alloc_predict(logic [2:0] kind, logic [31:0] lo,
                                           logic [31:0] hi, logic [31:0] num);
    grant_t g;
    int pos;
    g = '0;
    case (req_type_e'(kind))
      REQ_ADD: begin
        if (blk_cnt < MaxBlocks) begin
          pos = 0;
          // equal starts: new block goes behind the old ones
          while (pos < blk_cnt && blk_start[pos] <= lo) pos++;
          for (int k = blk_cnt; k > pos; k--) copy_blk(k, k - 1);
          blk_start[pos] = lo;
          blk_end[pos]   = hi;
          blk_last[pos]  = '0;
          blk_used[pos]  = 1'b0;
          blk_cnt++;
          g.ok = 1'b1;
        end
      end
      REQ_GET: begin
        for (int k = 0; k < blk_cnt; k++) begin
          if (!blk_used[k]) begin
            g.ok = 1'b1;
            g.free_num = blk_start[k];
            break;
          end
          if (blk_last[k] < blk_end[k]) begin
            g.ok = 1'b1;
            g.free_num = blk_last[k] + 32'd1;
            break;
          end
        end
      end
      REQ_USE: begin
        for (int k = 0; k < blk_cnt; k++) begin
          if (blk_start[k] <= num && blk_end[k] >= num) begin
            blk_last[k] = num;
            blk_used[k] = 1'b1;
            g.ok = 1'b1;
            break;
          end
        end
      end
      REQ_DEL: begin
        for (int k = 0; k < blk_cnt; k++) begin
          if (blk_start[k] == lo) begin
            for (int m = k; m + 1 < blk_cnt; m++) copy_blk(m, m + 1);
            blk_cnt--;
            g.ok = 1'b1;
            break;
          end
        end
      end
      REQ_QUERY: begin
        for (int k = 0; k < blk_cnt; k++) if (!blk_used[k]) g.ok = 1'b1;
      end
      default: ;
    endcase
    return g;
  endfunction

  // Predict on each accepted request, check each accepted grant.
  always @(posedge clk_i) begin
    grant_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (grant_q.size() == 0) begin
        $error("grant with no request pending: ok=%0d free_number=%0h",
               m_axis_tuser[0], m_axis_tdata);
        mismatches++;
      end else begin
        want = grant_q.pop_front();
        if (m_axis_tuser[0] !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tdata !== want.free_num) begin
          $error("free_number: expected %0h, got %0h", want.free_num, m_axis_tdata);
          mismatches++;
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      want = alloc_predict(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                           s_axis_tdata[95:64]);
      grant_q.push_back(word_typed ? word_grant : want);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck <= 0;
    end else if (stuck >= StuckLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // Result side: random back-pressure plus one long hold to fill the block.
  initial begin
    repeat (4) @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!hold_done && words_sent >= HoldAfter) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        hold_done = 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic [2:0] kind, logic [31:0] lo, logic [31:0] hi,
                           logic [31:0] num, logic typed, grant_t g);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {num, hi, lo};
    word_typed    <= typed;
    word_grant    <= g;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  // Mostly sequences that fill, use up and drain the table; some noise.
  task automatic pick_request(output logic [2:0] kind, output logic [31:0] lo,
                              output logic [31:0] hi, output logic [31:0] num);
    int r;
    int j;
    int add_w;
    int del_w;
    logic [31:0] span;
    kind = REQ_QUERY;
    lo = $urandom;
    hi = $urandom;
    num = $urandom;
    add_w = grow ? 40 : 6;
    del_w = grow ? 5 : 30;
    r = $urandom_range(0, 99);
    if (r < add_w) begin
      kind = REQ_ADD;
      span = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, span_max);
      if ($urandom_range(0, 3) != 0) lo = region_base + $urandom_range(0, 4 * span_max + 3);
      if ($urandom_range(0, 9) == 0 && pool_start.size() != 0)
        lo = pool_start[$urandom_range(0, pool_start.size() - 1)];
      hi = lo + span;
      if ($urandom_range(0, 19) == 0) hi = lo - $urandom_range(1, 50);
      pool_start.push_back(lo);
      pool_end.push_back(hi);
      if (pool_start.size() > 24) begin
        void'(pool_start.pop_front());
        void'(pool_end.pop_front());
      end
    end else if (r < add_w + del_w) begin
      kind = REQ_DEL;
      if (pool_start.size() != 0 && $urandom_range(0, 9) != 0) begin
        j = $urandom_range(0, pool_start.size() - 1);
        lo = pool_start[j];
        pool_start.delete(j);
        pool_end.delete(j);
      end
    end else if (r < add_w + del_w + 20) begin
      kind = REQ_GET;
    end else if (r < add_w + del_w + 45) begin
      kind = REQ_USE;
      if (pool_start.size() != 0 && $urandom_range(0, 9) != 0) begin
        j = $urandom_range(0, pool_start.size() - 1);
        case ($urandom_range(0, 3))
          0: num = pool_start[j];
          1: num = pool_end[j];
          default: num = pool_start[j] + $urandom_range(0, span_max);
        endcase
      end
    end else if (r < add_w + del_w + 51) begin
      kind = REQ_QUERY;
    end else if (r < add_w + del_w + 53) begin
      kind = REQ_RSV5 + 3'($urandom_range(0, 2));
    end else begin
      kind = 3'($urandom_range(0, 7));
    end
  endtask

  initial begin
    logic [2:0]  kind;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] num;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i])
      send_word(DIRECTED[i].kind, DIRECTED[i].lo, DIRECTED[i].hi, DIRECTED[i].num,
                DIRECTED[i].typed, {DIRECTED[i].ok, DIRECTED[i].free_num});

    for (int i = 0; i < RandItems; i++) begin
      if (i >= RandItems - QuietItems) begin
        idle_pct = 0;
      end else if (i % 80 == 0) begin
        grow = ~grow;
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 5;
          2: idle_pct = 20;
          default: idle_pct = 40;
        endcase
        case ($urandom_range(0, 3))
          0: span_max = 0;
          1: span_max = 3;
          2: span_max = 63;
          default: span_max = 1000;
        endcase
        case ($urandom_range(0, 3))
          0: region_base = '0;
          1: region_base = 32'hFFFF_F000;
          default: region_base = $urandom;
        endcase
      end
      pick_request(kind, lo, hi, num);
      send_word(kind, lo, hi, num, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
